[rtl/bmo_pkg.sv]
// ----------------------------------------------------------------------------
// bmo_pkg
// Shared types, widths, constants and tables of the bicycle model odometry.
// ----------------------------------------------------------------------------
package bmo_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  localparam int CORDIC_IW    = $clog2(CORDIC_ITERS);

  localparam int MA = 50;
  localparam int MB = 34;
  localparam int MP = MA + MB;
  localparam int MULT_CW = $clog2(MB);

  localparam int DN = 50;
  localparam int DD = 34;
  localparam int DIV_CW = $clog2(DN);

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032875;
  localparam logic [31:0] TURN_PER_RAD = 32'd683565276;

  localparam logic [1:0] REG_STEP_TIME       = 2'd0;
  localparam logic [1:0] REG_INV_WHEELBASE   = 2'd1;
  localparam logic [1:0] REG_INV_STEER_RATIO = 2'd2;

  localparam logic [15:0] STEP_TIME_RST       = 16'd1311;
  localparam logic [15:0] INV_WHEELBASE_RST   = 16'd21674;
  localparam logic [15:0] INV_STEER_RATIO_RST = 16'd4096;

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef enum logic [3:0] {
    S_IDLE, S_DIST, S_CORD_H, S_MUL_X, S_MUL_Y, S_MUL_RAD, S_MUL_ROAD,
    S_CORD_R, S_DIV, S_MUL_A, S_MUL_T, S_MUL_H, S_EMIT
  } bmo_state_t;

  function automatic logic [31:0] atan_val(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sh0000_7fff_ffff) r = S32_MAX;
    else if (v < -48'sh0000_8000_0000) r = S32_MIN;
    else r = v[31:0];
    return r;
  endfunction

endpackage

[rtl/bmo_if.sv]
// ----------------------------------------------------------------------------
// bmo_if
// Request and result channels of the bicycle model odometry.
// ----------------------------------------------------------------------------
interface bmo_req_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [15:0] speed;
  logic signed [15:0] steer_wheel_angle;
  logic [39:0]        gps_east;
  logic [39:0]        gps_north;

  modport source (output valid, req_type, speed, steer_wheel_angle, gps_east, gps_north,
                  input ready);
  modport sink (input valid, req_type, speed, steer_wheel_angle, gps_east, gps_north,
                output ready);
endinterface

interface bmo_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [15:0] heading;

  modport source (output valid, pos_x, pos_y, heading, input ready);
  modport sink (input valid, pos_x, pos_y, heading, output ready);
endinterface

[rtl/bicycle_model_odometry.sv]
// ----------------------------------------------------------------------------
// bicycle_model_odometry
// Dead-reckoning odometry for a kinematic bicycle model with fix overwrite.
// ----------------------------------------------------------------------------
// A fix item is stored at its accept. A tick item gives one result item, and
// no new item is taken until it is done: eight products on the shared
// bit-serial multiplier set most of its work, plus two CORDIC runs, a
// bit-serial divide for the steering tangent and the accept and emit steps.
// Results sit in an output register, so a new item is taken while an earlier
// result waits.
module bicycle_model_odometry (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data,
  bmo_req_if.sink    req,
  bmo_res_if.source  res
);

  bmo_pkg::bmo_state_t state, state_next;

  logic [15:0] step_time;
  logic [15:0] inv_wheelbase;
  logic [15:0] inv_steer_ratio;

  logic signed [31:0] est_x, est_y, pending_x, pending_y;
  logic [15:0]        est_heading;
  logic [39:0]        ref_east, ref_north;
  logic               have_reference, fix_pending;

  logic signed [15:0] speed, steer;
  logic signed [32:0] step_dist, rad;
  logic signed [33:0] cc, cs, a_reg;
  logic [31:0]        road;
  logic signed [31:0] tq;
  logic signed [49:0] rad2;
  logic               issued;
  logic               res_valid;

  logic                          m_start, m_done;
  logic signed [bmo_pkg::MA-1:0] m_a;
  logic signed [bmo_pkg::MB-1:0] m_b;
  logic signed [bmo_pkg::MP-1:0] m_p;
  logic                          c_start, c_done;
  logic [31:0]                   c_ang;
  logic signed [33:0]            c_c, c_s;
  logic                          d_start;
  logic                          d_done;
  logic [bmo_pkg::DN-1:0]        d_quo;
  logic                          done_any;

  logic               acc;
  logic signed [46:0] t47;
  logic signed [47:0] sum_x, sum_y;
  logic signed [47:0] fe, fn;
  logic [33:0]        s_mag, c_mag;
  logic signed [32:0] t33;
  logic signed [35:0] t36;
  logic signed [51:0] t52;
  logic [16:0]        t17;
  logic               q_big, q_neg;

  bmo_mult u_mult (.clk, .rst, .start(m_start), .a(m_a), .b(m_b), .done(m_done), .p(m_p));
  bmo_cordic u_cordic (.clk, .rst, .start(c_start), .ang(c_ang), .done(c_done),
                       .c(c_c), .s(c_s));
  bmo_div u_div (.clk, .rst, .start(d_start), .num({s_mag, 16'd0}), .den(c_mag),
                 .done(d_done), .quo(d_quo));

  assign done_any  = m_done | c_done | d_done;
  assign acc       = req.valid && req.ready;
  assign res.valid = res_valid;

  always_comb begin
    state_next = state;
    unique case (state)
      bmo_pkg::S_IDLE:     if (acc && !req.req_type) state_next = bmo_pkg::S_DIST;
      bmo_pkg::S_DIST:     if (done_any) state_next = bmo_pkg::S_CORD_H;
      bmo_pkg::S_CORD_H:   if (done_any) state_next = bmo_pkg::S_MUL_X;
      bmo_pkg::S_MUL_X:    if (done_any) state_next = bmo_pkg::S_MUL_Y;
      bmo_pkg::S_MUL_Y:    if (done_any) state_next = bmo_pkg::S_MUL_RAD;
      bmo_pkg::S_MUL_RAD:  if (done_any) state_next = bmo_pkg::S_MUL_ROAD;
      bmo_pkg::S_MUL_ROAD: if (done_any) state_next = bmo_pkg::S_CORD_R;
      bmo_pkg::S_CORD_R:   if (done_any) state_next = bmo_pkg::S_DIV;
      bmo_pkg::S_DIV:      if (done_any) state_next = bmo_pkg::S_MUL_A;
      bmo_pkg::S_MUL_A:    if (done_any) state_next = bmo_pkg::S_MUL_T;
      bmo_pkg::S_MUL_T:    if (done_any) state_next = bmo_pkg::S_MUL_H;
      bmo_pkg::S_MUL_H:    if (done_any) state_next = bmo_pkg::S_EMIT;
      bmo_pkg::S_EMIT:     if (!res_valid || res.ready) state_next = bmo_pkg::S_IDLE;
      default:             state_next = bmo_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req.ready  = (state == bmo_pkg::S_IDLE);
    m_start    = 1'b0;
    c_start    = 1'b0;
    d_start    = 1'b0;
    m_a        = '0;
    m_b        = '0;
    c_ang      = road;
    unique case (state) inside
      bmo_pkg::S_DIST, bmo_pkg::S_MUL_X, bmo_pkg::S_MUL_Y, bmo_pkg::S_MUL_RAD,
      bmo_pkg::S_MUL_ROAD, bmo_pkg::S_MUL_A, bmo_pkg::S_MUL_T, bmo_pkg::S_MUL_H:
        m_start = !issued;
      bmo_pkg::S_CORD_H, bmo_pkg::S_CORD_R:
        c_start = !issued;
      bmo_pkg::S_DIV:
        d_start = !issued;
      default: ;
    endcase
    unique case (state)
      bmo_pkg::S_DIST: begin
        m_a = bmo_pkg::MA'(speed);
        m_b = $signed({18'd0, step_time});
      end
      bmo_pkg::S_MUL_X: begin
        m_a = bmo_pkg::MA'(step_dist);
        m_b = cc;
      end
      bmo_pkg::S_MUL_Y: begin
        m_a = bmo_pkg::MA'(step_dist);
        m_b = cs;
      end
      bmo_pkg::S_MUL_RAD: begin
        m_a = bmo_pkg::MA'(steer);
        m_b = $signed({18'd0, inv_steer_ratio});
      end
      bmo_pkg::S_MUL_ROAD: begin
        m_a = bmo_pkg::MA'(rad);
        m_b = $signed({2'd0, bmo_pkg::TURN_PER_RAD});
      end
      bmo_pkg::S_MUL_A: begin
        m_a = bmo_pkg::MA'(step_dist);
        m_b = $signed({18'd0, inv_wheelbase});
      end
      bmo_pkg::S_MUL_T: begin
        m_a = bmo_pkg::MA'(a_reg);
        m_b = bmo_pkg::MB'(tq);
      end
      bmo_pkg::S_MUL_H: begin
        m_a = rad2;
        m_b = $signed({2'd0, bmo_pkg::TURN_PER_RAD});
      end
      bmo_pkg::S_CORD_H: c_ang = {est_heading, 16'd0};
      default: ;
    endcase
  end

  always_comb begin
    t47   = m_p[83:37] + 47'sd1;
    sum_x = 48'(est_x) + 48'($signed(t47[46:1]));
    sum_y = 48'(est_y) + 48'($signed(t47[46:1]));
    fe    = $signed({8'd0, req.gps_east}) - $signed({8'd0, ref_east});
    fn    = $signed({8'd0, req.gps_north}) - $signed({8'd0, ref_north});
    s_mag = cs[33] ? 34'(-cs) : 34'(cs);
    c_mag = cc[33] ? 34'(-cc) : 34'(cc);
    t33   = m_p[59:27] + 33'sd1;
    t36   = m_p[50:15] + 36'sd1;
    t52   = m_p[66:15] + 52'sd1;
    t17   = m_p[55:39] + 17'd1;
    q_big = |d_quo[49:31];
    q_neg = cs[33] ^ cc[33];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= bmo_pkg::S_IDLE;
      issued          <= 1'b0;
      res_valid       <= 1'b0;
      step_time       <= bmo_pkg::STEP_TIME_RST;
      inv_wheelbase   <= bmo_pkg::INV_WHEELBASE_RST;
      inv_steer_ratio <= bmo_pkg::INV_STEER_RATIO_RST;
      est_x           <= '0;
      est_y           <= '0;
      est_heading     <= '0;
      ref_east        <= '0;
      ref_north       <= '0;
      have_reference  <= 1'b0;
      fix_pending     <= 1'b0;
      pending_x       <= '0;
      pending_y       <= '0;
    end else begin
      state <= state_next;
      if (m_start || c_start || d_start) begin
        issued <= 1'b1;
      end else if (done_any) begin
        issued <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          bmo_pkg::REG_STEP_TIME:       step_time       <= cfg_data;
          bmo_pkg::REG_INV_WHEELBASE:   inv_wheelbase   <= cfg_data;
          bmo_pkg::REG_INV_STEER_RATIO: inv_steer_ratio <= cfg_data;
          default: ;
        endcase
      end
      if (acc && req.req_type) begin
        if (!have_reference) begin
          ref_east       <= req.gps_east;
          ref_north      <= req.gps_north;
          have_reference <= 1'b1;
        end else begin
          pending_x   <= bmo_pkg::sat32(fe);
          pending_y   <= bmo_pkg::sat32(fn);
          fix_pending <= 1'b1;
        end
      end
      if (done_any) begin
        case (state)
          bmo_pkg::S_MUL_X: est_x <= bmo_pkg::sat32(sum_x);
          bmo_pkg::S_MUL_Y: begin
            if (fix_pending) begin
              est_x       <= pending_x;
              est_y       <= pending_y;
              fix_pending <= 1'b0;
            end else begin
              est_y <= bmo_pkg::sat32(sum_y);
            end
          end
          bmo_pkg::S_MUL_H: est_heading <= est_heading + t17[16:1];
          default: ;
        endcase
      end
      if (state == bmo_pkg::S_EMIT && (!res_valid || res.ready)) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      speed <= req.speed;
      steer <= req.steer_wheel_angle;
    end
    if (c_done) begin
      cc <= c_c;
      cs <= c_s;
    end
    if (m_done) begin
      case (state)
        bmo_pkg::S_DIST:     step_dist <= m_p[32:0];
        bmo_pkg::S_MUL_RAD:  rad       <= m_p[32:0];
        bmo_pkg::S_MUL_ROAD: road      <= t33[32:1];
        bmo_pkg::S_MUL_A:    a_reg     <= t36[34:1];
        bmo_pkg::S_MUL_T:    rad2      <= t52[50:1];
        default: ;
      endcase
    end
    if (d_done) begin
      if (c_mag == '0) begin
        tq <= cs[33] ? bmo_pkg::S32_MIN : bmo_pkg::S32_MAX;
      end else if (q_neg) begin
        tq <= q_big ? bmo_pkg::S32_MIN : -$signed(d_quo[31:0]);
      end else begin
        tq <= q_big ? bmo_pkg::S32_MAX : $signed(d_quo[31:0]);
      end
    end
    if (state == bmo_pkg::S_EMIT && (!res_valid || res.ready)) begin
      res.pos_x   <= est_x;
      res.pos_y   <= est_y;
      res.heading <= est_heading;
    end
  end

  a_done_issued: assert property (@(posedge clk) disable iff (rst) done_any |-> issued)
    else $error("unit finished without a start");

  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    $onehot0({m_done, c_done, d_done}))
    else $error("more than one unit finished at once");

  a_fix_heading: assert property (@(posedge clk) disable iff (rst)
    (acc && req.req_type) |=> $stable(est_heading))
    else $error("fix item changed the heading");

  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    (state == bmo_pkg::S_EMIT && res_valid && !res.ready) |=> (state == bmo_pkg::S_EMIT))
    else $error("result overwritten before it was taken");

endmodule

[rtl/bmo_mult.sv]
// ----------------------------------------------------------------------------
// bmo_mult
// Bit-serial signed multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module bmo_mult (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [bmo_pkg::MA-1:0] a,
  input  logic signed [bmo_pkg::MB-1:0] b,
  output logic                         done,
  output logic signed [bmo_pkg::MP-1:0] p
);

  logic                             busy;
  logic [bmo_pkg::MULT_CW-1:0]      cnt;
  logic signed [bmo_pkg::MA:0]      hi;
  logic [bmo_pkg::MB-1:0]           lo;
  logic signed [bmo_pkg::MA-1:0]    mcand;
  logic signed [bmo_pkg::MA+1:0]    ax;
  logic signed [bmo_pkg::MA+1:0]    hix;
  logic signed [bmo_pkg::MA+1:0]    addend;
  logic signed [bmo_pkg::MA+1:0]    sum;
  logic                             last;

  always_comb begin
    ax     = {{2{mcand[bmo_pkg::MA-1]}}, mcand};
    hix    = {hi[bmo_pkg::MA], hi};
    last   = (cnt == bmo_pkg::MULT_CW'(bmo_pkg::MB - 1));
    addend = '0;
    if (lo[0]) begin
      addend = last ? -ax : ax;
    end
    sum = hix + addend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hi    <= '0;
      lo    <= b;
      mcand <= a;
    end else if (busy) begin
      hi <= sum[bmo_pkg::MA+1:1];
      lo <= {sum[0], lo[bmo_pkg::MB-1:1]};
    end
  end

  assign p = {hi[bmo_pkg::MA-1:0], lo};

endmodule

[rtl/bmo_cordic.sv]
// ----------------------------------------------------------------------------
// bmo_cordic
// Iterative rotation-mode CORDIC giving cosine and sine of a binary angle.
// ----------------------------------------------------------------------------
module bmo_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        ang,
  output logic               done,
  output logic signed [33:0] c,
  output logic signed [33:0] s
);

  logic                          busy;
  logic [bmo_pkg::CORDIC_IW-1:0] i;
  logic signed [33:0]            x;
  logic signed [33:0]            y;
  logic signed [32:0]            z;
  logic                          flip;
  logic                          flip_in;
  logic [31:0]                   ang_f;
  logic signed [33:0]            x_n;
  logic signed [33:0]            y_n;
  logic signed [32:0]            z_n;
  logic signed [32:0]            at;
  logic                          last;

  always_comb begin
    flip_in = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
    ang_f   = flip_in ? (ang ^ 32'h8000_0000) : ang;
    at      = $signed({1'b0, bmo_pkg::atan_val(5'(i))});
    last    = (i == bmo_pkg::CORDIC_IW'(bmo_pkg::CORDIC_ITERS - 1));
    if (!z[32]) begin
      x_n = x - (y >>> i);
      y_n = y + (x >>> i);
      z_n = z - at;
    end else begin
      x_n = x + (y >>> i);
      y_n = y - (x >>> i);
      z_n = z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      i    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        i    <= '0;
      end else if (busy) begin
        i <= i + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= bmo_pkg::CORDIC_GAIN;
      y    <= '0;
      z    <= $signed({ang_f[31], ang_f});
      flip <= flip_in;
    end else if (busy) begin
      x <= x_n;
      y <= y_n;
      z <= z_n;
      if (last) begin
        c <= flip ? -x_n : x_n;
        s <= flip ? -y_n : y_n;
      end
    end
  end

endmodule

[rtl/bmo_div.sv]
// ----------------------------------------------------------------------------
// bmo_div
// Bit-serial restoring divider on unsigned magnitudes, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module bmo_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [bmo_pkg::DN-1:0]    num,
  input  logic [bmo_pkg::DD-1:0]    den,
  output logic                      done,
  output logic [bmo_pkg::DN-1:0]    quo
);

  logic                          busy;
  logic [bmo_pkg::DIV_CW-1:0]    cnt;
  logic [bmo_pkg::DD-1:0]        rem;
  logic [bmo_pkg::DD-1:0]        dreg;
  logic [bmo_pkg::DD:0]          trial;
  logic [bmo_pkg::DD:0]          diff;
  logic                          ge;
  logic                          last;

  always_comb begin
    trial = {rem, quo[bmo_pkg::DN-1]};
    diff  = trial - {1'b0, dreg};
    ge    = (trial >= {1'b0, dreg});
    last  = (cnt == bmo_pkg::DIV_CW'(bmo_pkg::DN - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= num;
      dreg <= den;
    end else if (busy) begin
      rem <= ge ? diff[bmo_pkg::DD-1:0] : trial[bmo_pkg::DD-1:0];
      quo <= {quo[bmo_pkg::DN-2:0], ge};
    end
  end

endmodule

[verif/bicycle_model_odometry_tb.sv]
// ----------------------------------------------------------------------------
// bicycle_model_odometry_tb
// Drives fix and tick items through the odometry block under several register
// settings with random source gaps and sink stalls, and compares every pose
// item with an in-bench bit-exact model of the dead-reckoning arithmetic.
// ----------------------------------------------------------------------------
module bicycle_model_odometry_tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 400;
  localparam int LONG_HOLD      = 3000;

  typedef struct {
    bit               is_fix;
    logic signed [15:0] speed;
    logic signed [15:0] steer;
    logic [39:0]      east;
    logic [39:0]      north;
  } odo_req_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [15:0] hd;
  } pose_t;

  class PoseScoreboard;
    longint    step_time, inv_wb, inv_ratio;
    longint    est_x, est_y, pend_x, pend_y, ref_e, ref_n;
    bit [15:0] heading;
    bit        have_ref, fix_pending;
    pose_t     pose_q[$];
    int        mismatches;
    bit [31:0] arctan[24];

    function new();
      arctan = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
                 32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
                 32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
                 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
                 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
      step_time = longint'(bmo_pkg::STEP_TIME_RST);
      inv_wb = longint'(bmo_pkg::INV_WHEELBASE_RST);
      inv_ratio = longint'(bmo_pkg::INV_STEER_RATIO_RST);
      est_x = 0; est_y = 0; pend_x = 0; pend_y = 0; ref_e = 0; ref_n = 0;
      heading = 0; have_ref = 0; fix_pending = 0; mismatches = 0;
    endfunction

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint rnd(longint v, int sh);
      longint one;
      one = 1;
      return (v + (one <<< (sh - 1))) >>> sh;
    endfunction

    function void rotate(bit [31:0] ang, output longint c, output longint s);
      bit     flip;
      longint x, y, z, t;
      flip = 0;
      x = 652032875;
      y = 0;
      if (ang[31:30] == 2'd1 || ang[31:30] == 2'd2) begin
        flip = 1;
        ang = ang - 32'h80000000;
      end
      z = longint'(int'(ang));
      for (int i = 0; i < bmo_pkg::CORDIC_ITERS; i++) begin
        if (z >= 0) begin
          t = x - (y >>> i);
          y = y + (x >>> i);
          z = z - longint'(arctan[i]);
        end else begin
          t = x + (y >>> i);
          y = y - (x >>> i);
          z = z + longint'(arctan[i]);
        end
        x = t;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] v);
      case (idx)
        bmo_pkg::REG_STEP_TIME:       step_time = longint'(v);
        bmo_pkg::REG_INV_WHEELBASE:   inv_wb = longint'(v);
        bmo_pkg::REG_INV_STEER_RATIO: inv_ratio = longint'(v);
        default: ;
      endcase
    endfunction

    function void note_request(odo_req_t r);
      longint    step_dist, c, s, rad, tq, a, rad2;
      bit [63:0] u;
      bit [31:0] road;
      pose_t     p;
      if (r.is_fix) begin
        if (!have_ref) begin
          ref_e = longint'(r.east);
          ref_n = longint'(r.north);
          have_ref = 1;
        end else begin
          pend_x = sat(longint'(r.east) - ref_e);
          pend_y = sat(longint'(r.north) - ref_n);
          fix_pending = 1;
        end
        return;
      end
      step_dist = step_time * longint'(r.speed);
      rotate({heading, 16'h0}, c, s);
      est_x = sat(est_x + rnd(step_dist * c, 38));
      est_y = sat(est_y + rnd(step_dist * s, 38));
      if (fix_pending) begin
        est_x = pend_x;
        est_y = pend_y;
        fix_pending = 0;
      end
      rad = longint'(r.steer) * inv_ratio;
      u = rad;
      u = u * 64'd683565276 + (64'd1 << 27);
      road = u[59:28];
      rotate(road, c, s);
      if (c != 0) tq = sat((s * 65536) / c);
      else tq = (s >= 0) ? 64'sd2147483647 : -64'sd2147483648;
      a = rnd(step_dist * inv_wb, 16);
      rad2 = rnd(a * tq, 16);
      u = rad2;
      u = u * 64'd683565276 + (64'd1 << 39);
      heading = heading + u[55:40];
      p.x = est_x[31:0];
      p.y = est_y[31:0];
      p.hd = heading;
      pose_q.push_back(p);
    endfunction

    function void check_pose(pose_t got);
      pose_t e;
      if (pose_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pose item x=%0d y=%0d hd=%0d", got.x, got.y, got.hd);
        return;
      end
      e = pose_q.pop_front();
      if (got.x !== e.x || got.y !== e.y || got.hd !== e.hd) begin
        mismatches++;
        if (mismatches <= 10)
          $display("pose mismatch: exp x=%0d y=%0d hd=%0d got x=%0d y=%0d hd=%0d",
                   e.x, e.y, e.hd, got.x, got.y, got.hd);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  bmo_req_if req ();
  bmo_res_if res ();

  bicycle_model_odometry DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req(req.sink), .res(res.source)
  );

  PoseScoreboard sb = new();
  int burst_left = 0;
  int hold_left = 0;
  bit hold_req = 0;
  int sink_mode = 0;
  int mode_left = 0;
  int idle_cycles = 0;

  always #4 clk = ~clk;

  initial begin
    req.valid = 0;
    req.req_type = 0;
    req.speed = '0;
    req.steer_wheel_angle = '0;
    req.gps_east = '0;
    req.gps_north = '0;
    res.ready = 0;
  end

  // sink stall patterns and the long hold-off
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res.ready <= 0;
    end else if (hold_req) begin
      hold_req = 0;
      hold_left <= LONG_HOLD;
      res.ready <= 0;
    end else begin
      if (mode_left == 0) begin
        sink_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 2000);
      end else begin
        mode_left = mode_left - 1;
      end
      case (sink_mode)
        0: res.ready <= 1;
        1: res.ready <= 1'($urandom_range(0, 1));
        default: res.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    pose_t got;
    if (!rst && res.valid && res.ready) begin
      got.x = res.pos_x;
      got.y = res.pos_y;
      got.hd = res.heading;
      sb.check_pose(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic send_request(odo_req_t r);
    if (burst_left == 0) begin
      req.valid <= 0;
      repeat ($urandom_range(1, 25)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    req.valid <= 1;
    req.req_type <= r.is_fix;
    req.speed <= r.speed;
    req.steer_wheel_angle <= r.steer;
    req.gps_east <= r.east;
    req.gps_north <= r.north;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sb.note_request(r);
    burst_left--;
  endtask

  task automatic drain_outstanding();
    req.valid <= 0;
    burst_left = 0;
    while (sb.pose_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic odo_req_t make_req(bit f, int sp, int st, logic [39:0] e,
                                        logic [39:0] n);
    odo_req_t r;
    r.is_fix = f;
    r.speed = 16'(sp);
    r.steer = 16'(st);
    r.east = e;
    r.north = n;
    return r;
  endfunction

  function automatic logic [39:0] rand40();
    logic [39:0] v;
    v = 40'({$urandom, $urandom});
    return v;
  endfunction

  function automatic odo_req_t random_req();
    odo_req_t r;
    longint   off;
    r.is_fix = ($urandom_range(0, 99) < 35);
    r.speed = 16'($urandom);
    if ($urandom_range(0, 1)) r.speed = 16'(int'($urandom_range(0, 4000)) - 2000);
    r.steer = 16'($urandom);
    r.east = rand40();
    r.north = rand40();
    if (r.is_fix && $urandom_range(0, 9) < 7) begin
      off = longint'($urandom_range(0, 32'h01FF_FFFF)) - 64'sh0100_0000;
      r.east = 40'(sb.ref_e + off);
      off = longint'($urandom_range(0, 32'h01FF_FFFF)) - 64'sh0100_0000;
      r.north = 40'(sb.ref_n + off);
    end
    return r;
  endfunction

  initial begin
    logic [15:0] regs[3];
    logic [39:0] mid;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    mid = 40'h80_0000_0000;

    // directed items at reset settings
    send_request(make_req(0, 256, 0, rand40(), rand40()));
    send_request(make_req(1, 12345, -77, mid, mid));
    send_request(make_req(0, 32767, 32767, '0, '0));
    send_request(make_req(1, 0, 0, 40'hFF_FFFF_FFFF, 40'h0));
    send_request(make_req(0, -32768, -32768, '0, '0));
    send_request(make_req(1, 0, 0, 40'h0, 40'hFF_FFFF_FFFF));
    send_request(make_req(1, 0, 0, mid + 40'd5000, mid - 40'd7000));
    send_request(make_req(1, 0, 0, mid - 40'd100, mid + 40'd300));
    send_request(make_req(0, 0, 0, rand40(), rand40()));
    send_request(make_req(0, 1, 1, '0, '0));
    send_request(make_req(0, -1, -1, '0, '0));
    send_request(make_req(0, 32767, 6434, '0, '0));
    send_request(make_req(0, -32768, -6434, '0, '0));
    drain_outstanding();
    write_reg(bmo_pkg::REG_INV_STEER_RATIO, 16'hFFFF);
    send_request(make_req(0, 2560, 6434, '0, '0));
    send_request(make_req(0, 2560, -6434, '0, '0));
    send_request(make_req(0, 32767, 32767, '0, '0));
    send_request(make_req(0, -32768, -32768, '0, '0));
    drain_outstanding();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: regs = '{bmo_pkg::STEP_TIME_RST, bmo_pkg::INV_WHEELBASE_RST,
                    bmo_pkg::INV_STEER_RATIO_RST};
        1: regs = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
        2: regs = '{16'd1, 16'd1, 16'd1};
        3: regs = '{16'd0, 16'($urandom), 16'd0};
        default: regs = '{16'($urandom), 16'($urandom), 16'($urandom)};
      endcase
      write_reg(bmo_pkg::REG_STEP_TIME, regs[0]);
      write_reg(bmo_pkg::REG_INV_WHEELBASE, regs[1]);
      write_reg(bmo_pkg::REG_INV_STEER_RATIO, regs[2]);
      for (int k = 0; k < 330; k++) begin
        if (ph == 1 && k == 100) hold_req = 1;
        if (ph == 4 && k == 150) begin
          req.valid <= 0;
          burst_left = 0;
          @(posedge clk);
          while (sb.pose_q.size() != 0) @(posedge clk);
        end
        send_request(random_req());
      end
      drain_outstanding();
    end

    if (sb.mismatches == 0 && sb.pose_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
